// ===== design/assert_macros.svh =====
// Assertion macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);
`endif

// ===== design/jrsc_pkg.sv =====
`timescale 1ns / 1ps
package jrsc_pkg;
    localparam int OFFSET_BITS = 40;
    localparam int CNT_BITS = 40;
    localparam logic [31:0] JR_MAGIC = 32'h41434A52;
    localparam logic [15:0] JR_VERSION = 16'd1;
    localparam logic [31:0] JR_HEADER_BYTES = 32'd20;
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [39:0] CNT_MAX = 40'hFF_FFFF_FFFF;
    localparam int QDEPTH = 4;
    localparam int QAW = 2;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_PAYLOAD = 3'd1,
        PH_CRC     = 3'd2,
        PH_PENDING = 3'd3,
        PH_ERROR   = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        K_APPLIED  = 3'd0,
        K_IGNORED  = 3'd1,
        K_END_OK   = 3'd2,
        K_END_TRUNC = 3'd3,
        K_HDR_ERR  = 3'd4,
        K_CRC_ERR  = 3'd5
    } t_kind;

    localparam logic REG_MAX_PAYLOAD = 1'b0;
    localparam logic REG_SKIP_SEQ = 1'b1;

    typedef struct packed {
        t_kind       kind;
        logic [63:0] record_sequence;
        logic [15:0] record_type;
        logic [31:0] payload_length;
        logic [39:0] byte_position;
        logic [39:0] applied_count;
        logic [39:0] ignored_count;
        logic        last_of_run;
    } t_result;

    function automatic logic [31:0] crc_byte(logic [31:0] c_in, logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction
endpackage

// ===== design/jrsc_front.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module jrsc_front (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_take,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_end_of_stream,
    input  logic [31:0] i_max_payload,
    input  logic [63:0] i_skip_seq,
    output logic        o_res0_valid,
    output logic        o_res1_valid,
    output jrsc_pkg::t_result o_res0,
    output jrsc_pkg::t_result o_res1
);
    jrsc_pkg::t_phase r_phase, n_phase;
    logic [31:0] r_left, n_left;
    logic [63:0] r_shift, n_shift;
    logic [15:0] r_type, n_type;
    logic [63:0] r_seq, n_seq;
    logic [31:0] r_len, n_len;
    logic [31:0] r_crc, n_crc;
    logic [31:0] r_rcrc, n_rcrc;
    logic [63:0] r_prev, n_prev;
    logic [jrsc_pkg::OFFSET_BITS-1:0] r_off, n_off, r_start, n_start, r_valid, n_valid;
    logic [39:0] r_app, n_app, r_ign, n_ign;
    logic r_bad, n_bad;
    logic [31:0] left_dec;
    logic [63:0] shift_new;
    logic        v0, v1;
    jrsc_pkg::t_result res0, res1;
    logic [39:0] start_pos, valid_pos;

    assign start_pos = 40'(r_start);

    always_comb begin
        n_phase = r_phase; n_left = r_left; n_shift = r_shift; n_type = r_type;
        n_seq = r_seq; n_len = r_len; n_crc = r_crc; n_rcrc = r_rcrc;
        n_prev = r_prev; n_off = r_off; n_start = r_start; n_valid = r_valid;
        n_app = r_app; n_ign = r_ign; n_bad = r_bad;
        v0 = 1'b0; v1 = 1'b0; res0 = '0; res1 = '0;
        left_dec = r_left - 32'd1;
        shift_new = {r_shift[55:0], i_data_byte};
        valid_pos = '0;
        if (i_byte_present) begin
            n_off = r_off + 1'b1;
            unique case (r_phase)
                jrsc_pkg::PH_PENDING: begin
                    v0 = 1'b1;
                    res0 = '{jrsc_pkg::K_CRC_ERR, r_seq, r_type, r_len, start_pos,
                             r_app, r_ign, 1'b0};
                    n_phase = jrsc_pkg::PH_ERROR;
                end
                jrsc_pkg::PH_ERROR: ;
                jrsc_pkg::PH_HEADER: begin
                    n_crc = jrsc_pkg::crc_byte(r_crc, i_data_byte);
                    n_shift = shift_new;
                    n_left = left_dec;
                    if (left_dec == 32'd16 && shift_new[31:0] != jrsc_pkg::JR_MAGIC)
                        n_bad = 1'b1;
                    if (left_dec == 32'd14 && shift_new[15:0] != jrsc_pkg::JR_VERSION)
                        n_bad = 1'b1;
                    if (left_dec == 32'd12) n_type = shift_new[15:0];
                    if (left_dec == 32'd4) n_seq = shift_new;
                    if (left_dec == 32'd0) begin
                        n_len = shift_new[31:0];
                        if (r_bad || r_type == 16'd0 || shift_new[31:0] > i_max_payload ||
                            r_seq == 64'd0 ||
                            (r_prev != 64'd0 && r_seq != r_prev + 64'd1)) begin
                            v0 = 1'b1;
                            res0 = '{jrsc_pkg::K_HDR_ERR, r_seq, r_type, shift_new[31:0],
                                     start_pos, r_app, r_ign, 1'b0};
                            n_phase = jrsc_pkg::PH_ERROR;
                        end else if (shift_new[31:0] == 32'd0) begin
                            n_phase = jrsc_pkg::PH_CRC; n_left = 32'd4;
                        end else begin
                            n_phase = jrsc_pkg::PH_PAYLOAD; n_left = shift_new[31:0];
                        end
                    end
                end
                jrsc_pkg::PH_PAYLOAD: begin
                    n_crc = jrsc_pkg::crc_byte(r_crc, i_data_byte);
                    n_left = left_dec;
                    if (left_dec == 32'd0) begin
                        n_phase = jrsc_pkg::PH_CRC; n_left = 32'd4;
                    end
                end
                jrsc_pkg::PH_CRC: begin
                    n_rcrc = {r_rcrc[23:0], i_data_byte};
                    n_left = left_dec;
                    if (left_dec == 32'd0) begin
                        if (n_rcrc == ~r_crc) begin
                            n_prev = r_seq;
                            n_valid = n_off;
                            if (r_seq <= i_skip_seq) begin
                                if (r_ign != jrsc_pkg::CNT_MAX) n_ign = r_ign + 40'd1;
                                res0.kind = jrsc_pkg::K_IGNORED;
                            end else begin
                                if (r_app != jrsc_pkg::CNT_MAX) n_app = r_app + 40'd1;
                                res0.kind = jrsc_pkg::K_APPLIED;
                            end
                            v0 = 1'b1;
                            res0.record_sequence = r_seq;
                            res0.record_type = r_type;
                            res0.payload_length = r_len;
                            res0.byte_position = start_pos;
                            res0.applied_count = n_app;
                            res0.ignored_count = n_ign;
                            n_phase = jrsc_pkg::PH_HEADER;
                            n_left = jrsc_pkg::JR_HEADER_BYTES;
                            n_shift = '0;
                            n_crc = '1;
                            n_rcrc = '0;
                            n_bad = 1'b0;
                            n_start = n_off;
                        end else begin
                            n_phase = jrsc_pkg::PH_PENDING;
                        end
                    end
                end
                default: ;
            endcase
        end
        if (i_end_of_stream) begin
            valid_pos = 40'(n_valid);
            res1 = '{jrsc_pkg::K_END_OK, n_prev, 16'd0, 32'd0, valid_pos,
                     n_app, n_ign, 1'b1};
            if (n_phase == jrsc_pkg::PH_PAYLOAD || n_phase == jrsc_pkg::PH_CRC ||
                n_phase == jrsc_pkg::PH_PENDING ||
                (n_phase == jrsc_pkg::PH_HEADER && n_left != jrsc_pkg::JR_HEADER_BYTES))
                res1.kind = jrsc_pkg::K_END_TRUNC;
            v1 = 1'b1;
        end else begin
            res0.last_of_run = v0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_end_of_stream)) begin
            r_phase <= jrsc_pkg::PH_HEADER; r_left <= jrsc_pkg::JR_HEADER_BYTES;
            r_shift <= '0; r_type <= '0; r_seq <= '0; r_len <= '0;
            r_crc <= '1; r_rcrc <= '0; r_prev <= '0; r_off <= '0;
            r_start <= '0; r_valid <= '0; r_app <= '0; r_ign <= '0; r_bad <= 1'b0;
        end else if (i_take) begin
            r_phase <= n_phase; r_left <= n_left; r_shift <= n_shift; r_type <= n_type;
            r_seq <= n_seq; r_len <= n_len; r_crc <= n_crc; r_rcrc <= n_rcrc;
            r_prev <= n_prev; r_off <= n_off; r_start <= n_start; r_valid <= n_valid;
            r_app <= n_app; r_ign <= n_ign; r_bad <= n_bad;
        end
    end

    assign o_res0_valid = i_take && v0;
    assign o_res1_valid = i_take && v1;
    assign o_res0 = res0;
    assign o_res1 = res1;

    `ASSERT_IMPL(a_err_sticky, i_clk, i_rst_n,
        $past(r_phase == jrsc_pkg::PH_ERROR && !(i_take && i_end_of_stream)),
        r_phase == jrsc_pkg::PH_ERROR, "error phase left before end of stream")
    `ASSERT_NEVER(a_crc_left, i_clk, i_rst_n,
        r_phase == jrsc_pkg::PH_CRC && (r_left == 32'd0 || r_left > 32'd4),
        "checksum byte count out of range")
endmodule

// ===== design/jrsc_queue.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module jrsc_queue (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr0,
    input  logic i_wr1,
    input  jrsc_pkg::t_result i_d0,
    input  jrsc_pkg::t_result i_d1,
    output logic o_room2,
    input  logic i_pop,
    output logic o_empty,
    output jrsc_pkg::t_result o_q
);
    jrsc_pkg::t_result r_mem [jrsc_pkg::QDEPTH];
    logic [jrsc_pkg::QAW-1:0] r_wp, r_rp;
    logic [jrsc_pkg::QAW:0] r_cnt;
    logic do_pop;
    logic [jrsc_pkg::QAW-1:0] wp1;

    assign do_pop = i_pop && (r_cnt != '0);
    assign wp1 = r_wp + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_wr0) r_mem[r_wp] <= i_d0;
        if (i_wr1) r_mem[i_wr0 ? wp1 : r_wp] <= i_d1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            r_wp <= r_wp + {1'b0, i_wr0} + {1'b0, i_wr1};
            if (do_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + {2'b0, i_wr0} + {2'b0, i_wr1} - {2'b0, do_pop};
        end
    end

    assign o_empty = (r_cnt == '0);
    assign o_q = r_mem[r_rp];
    assign o_room2 = (r_cnt <= (jrsc_pkg::QAW+1)'(jrsc_pkg::QDEPTH - 2));

    `ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n,
        (i_wr0 || i_wr1) && !o_room2, "result queue written without room")
endmodule

// ===== design/journal_record_stream_checker.sv =====
`timescale 1ns / 1ps
// Journal record stream checker: one stream byte per accepted item, one item per clock
// when the result side keeps up. The front end assembles headers, runs a bytewise
// CRC-32 step over header and payload bytes, checks each record and produces up to two
// result items per input (a record or error result, and the end-of-stream summary);
// these go into a four-entry result queue, and an item is accepted only while two
// slots are free, so full is high while three or more results are waiting. Payload
// bytes are consumed and not forwarded. Configuration writes are accepted every cycle.
module journal_record_stream_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_end_of_stream,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_kind,
    output logic [63:0] o_record_sequence,
    output logic [15:0] o_record_type,
    output logic [31:0] o_payload_length,
    output logic [39:0] o_byte_position,
    output logic [39:0] o_applied_count,
    output logic [39:0] o_ignored_count,
    output logic        o_last_of_run,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    logic [31:0] r_max_payload;
    logic [63:0] r_skip_seq;
    logic take, room2, w0, w1;
    jrsc_pkg::t_result d0, d1, q;

    // Register writes; a zero payload limit is stored as one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= 32'd65536;
            r_skip_seq <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                jrsc_pkg::REG_MAX_PAYLOAD:
                    r_max_payload <= (i_cfg_data[31:0] == 32'd0) ? 32'd1 : i_cfg_data[31:0];
                jrsc_pkg::REG_SKIP_SEQ: r_skip_seq <= i_cfg_data;
                default: ;
            endcase
        end
    end
    assign o_cfg_ready = 1'b1;

    assign full = !room2;
    assign take = push && room2;

    jrsc_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_take(take),
        .i_data_byte(i_data_byte), .i_byte_present(i_byte_present),
        .i_end_of_stream(i_end_of_stream), .i_max_payload(r_max_payload),
        .i_skip_seq(r_skip_seq), .o_res0_valid(w0), .o_res1_valid(w1),
        .o_res0(d0), .o_res1(d1)
    );

    jrsc_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_wr0(w0), .i_wr1(w1),
        .i_d0(d0), .i_d1(d1), .o_room2(room2), .i_pop(pop),
        .o_empty(empty), .o_q(q)
    );

    assign o_kind = q.kind;
    assign o_record_sequence = q.record_sequence;
    assign o_record_type = q.record_type;
    assign o_payload_length = q.payload_length;
    assign o_byte_position = q.byte_position;
    assign o_applied_count = q.applied_count;
    assign o_ignored_count = q.ignored_count;
    assign o_last_of_run = q.last_of_run;

    `ASSERT_IMPL(a_eos_result, i_clk, i_rst_n, take && i_end_of_stream, w1,
        "end of stream produced no summary")
endmodule

// ===== sim/tb_journal_record_stream_checker.sv =====
`timescale 1ns / 1ps
module tb_journal_record_stream_checker;

    // One input item of the journal byte stream.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_stream;
    } t_stream_item;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  i_data_byte = '0;
    logic        i_byte_present = 1'b0;
    logic        i_end_of_stream = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [2:0]  o_kind;
    logic [63:0] o_record_sequence;
    logic [15:0] o_record_type;
    logic [31:0] o_payload_length;
    logic [39:0] o_byte_position;
    logic [39:0] o_applied_count;
    logic [39:0] o_ignored_count;
    logic        o_last_of_run;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = 1'b0;
    logic [63:0] i_cfg_data = '0;

    journal_record_stream_checker dut (.*);

    always #10 i_clk = ~i_clk;

    // Items waiting to be driven, and results the block still owes us.
    t_stream_item      pending_bytes[$];
    jrsc_pkg::t_result owed_results[$];
    int                mismatch_count = 0;
    bit                sender_hold = 1'b0;
    bit                receiver_hold = 1'b0;

    // Predictor state, mirroring the block's registers and stream walker.
    logic [31:0]      lim_payload;
    logic [63:0]      skip_seq;
    jrsc_pkg::t_phase p_phase;
    logic [31:0]      p_left;
    logic [63:0]      p_shift;
    logic [15:0]      p_type;
    logic [63:0]      p_seq;
    logic [31:0]      p_len;
    logic [31:0]      p_crc;
    logic [31:0]      p_rx_crc;
    logic [63:0]      p_prev_seq;
    logic [39:0]      p_offset;
    logic [39:0]      p_start;
    logic [39:0]      p_valid;
    logic [39:0]      p_applied;
    logic [39:0]      p_ignored;
    logic             p_hdr_bad;

    // Bitwise reflected CRC-32 step, written independently of the package.
    function automatic logic [31:0] crc32_step(logic [31:0] c, logic [7:0] b);
        logic [31:0] r;
        r = c;
        for (int i = 0; i < 8; i++) begin
            r = (r[0] ^ b[i]) ? ((r >> 1) ^ 32'hEDB88320) : (r >> 1);
        end
        return r;
    endfunction

    task automatic restart_stream();
        p_phase = jrsc_pkg::PH_HEADER;
        p_left = 32'd20;
        p_shift = '0;
        p_type = '0;
        p_seq = '0;
        p_len = '0;
        p_crc = '1;
        p_rx_crc = '0;
        p_prev_seq = '0;
        p_offset = '0;
        p_start = '0;
        p_valid = '0;
        p_applied = '0;
        p_ignored = '0;
        p_hdr_bad = 1'b0;
    endtask

    function automatic jrsc_pkg::t_result make_result(jrsc_pkg::t_kind k, logic [63:0] seq,
                                                      logic [15:0] typ, logic [31:0] len,
                                                      logic [39:0] pos);
        jrsc_pkg::t_result r;
        r.kind = k;
        r.record_sequence = seq;
        r.record_type = typ;
        r.payload_length = len;
        r.byte_position = pos;
        r.applied_count = p_applied;
        r.ignored_count = p_ignored;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    // Walks one accepted item through the predictor and queues the results it causes.
    task automatic predict_stream_item(t_stream_item it);
        jrsc_pkg::t_result produced[$];
        jrsc_pkg::t_kind   k;
        logic [7:0] b;
        b = it.data_byte;
        if (it.byte_present) begin
            p_offset = p_offset + 40'd1;
            case (p_phase)
                jrsc_pkg::PH_PENDING: begin
                    // A byte after a bad CRC proves the record was not the tail.
                    produced.insert(produced.size(), make_result(jrsc_pkg::K_CRC_ERR,
                                    p_seq, p_type, p_len, p_start));
                    p_phase = jrsc_pkg::PH_ERROR;
                end
                jrsc_pkg::PH_ERROR: ;
                jrsc_pkg::PH_HEADER: begin
                    p_crc = crc32_step(p_crc, b);
                    p_shift = {p_shift[55:0], b};
                    p_left = p_left - 32'd1;
                    case (p_left)
                        32'd16: if (p_shift[31:0] != 32'h41434A52) p_hdr_bad = 1'b1;
                        32'd14: if (p_shift[15:0] != 16'd1) p_hdr_bad = 1'b1;
                        32'd12: p_type = p_shift[15:0];
                        32'd4:  p_seq = p_shift;
                        32'd0: begin
                            p_len = p_shift[31:0];
                            if (p_hdr_bad || p_type == 0 || p_len > lim_payload
                                    || p_seq == 0
                                    || (p_prev_seq != 0 && p_seq != p_prev_seq + 64'd1)) begin
                                produced.insert(produced.size(),
                                                make_result(jrsc_pkg::K_HDR_ERR, p_seq,
                                                            p_type, p_len, p_start));
                                p_phase = jrsc_pkg::PH_ERROR;
                            end else if (p_len == 0) begin
                                p_phase = jrsc_pkg::PH_CRC;
                                p_left = 32'd4;
                            end else begin
                                p_phase = jrsc_pkg::PH_PAYLOAD;
                                p_left = p_len;
                            end
                        end
                        default: ;
                    endcase
                end
                jrsc_pkg::PH_PAYLOAD: begin
                    p_crc = crc32_step(p_crc, b);
                    p_left = p_left - 32'd1;
                    if (p_left == 0) begin
                        p_phase = jrsc_pkg::PH_CRC;
                        p_left = 32'd4;
                    end
                end
                default: begin
                    p_rx_crc = {p_rx_crc[23:0], b};
                    p_left = p_left - 32'd1;
                    if (p_left == 0) begin
                        if (p_rx_crc == ~p_crc) begin
                            p_prev_seq = p_seq;
                            p_valid = p_offset;
                            if (p_seq <= skip_seq) begin
                                if (p_ignored != jrsc_pkg::CNT_MAX) p_ignored++;
                                k = jrsc_pkg::K_IGNORED;
                            end else begin
                                if (p_applied != jrsc_pkg::CNT_MAX) p_applied++;
                                k = jrsc_pkg::K_APPLIED;
                            end
                            produced.insert(produced.size(),
                                            make_result(k, p_seq, p_type, p_len, p_start));
                            p_phase = jrsc_pkg::PH_HEADER;
                            p_left = 32'd20;
                            p_shift = '0;
                            p_crc = '1;
                            p_rx_crc = '0;
                            p_hdr_bad = 1'b0;
                            p_start = p_offset;
                        end else begin
                            p_phase = jrsc_pkg::PH_PENDING;
                        end
                    end
                end
            endcase
        end
        if (it.end_of_stream) begin
            k = jrsc_pkg::K_END_OK;
            if (p_phase == jrsc_pkg::PH_PAYLOAD || p_phase == jrsc_pkg::PH_CRC
                    || p_phase == jrsc_pkg::PH_PENDING
                    || (p_phase == jrsc_pkg::PH_HEADER && p_left != 32'd20))
                k = jrsc_pkg::K_END_TRUNC;
            produced.insert(produced.size(), make_result(k, p_prev_seq, '0, '0, p_valid));
            restart_stream();
        end
        if (produced.size() > 0) produced[produced.size()-1].last_of_run = 1'b1;
        foreach (produced[i]) owed_results.insert(owed_results.size(), produced[i]);
    endtask

    // Stimulus builders.
    task automatic add_byte(logic [7:0] b, bit eos = 1'b0);
        pending_bytes.insert(pending_bytes.size(),
                             '{data_byte: b, byte_present: 1'b1, end_of_stream: eos});
    endtask

    task automatic add_bare_end();
        pending_bytes.insert(pending_bytes.size(),
                             '{data_byte: 8'($urandom), byte_present: 1'b0,
                               end_of_stream: 1'b1});
    endtask

    // Queues a whole record; corrupt selects which part gets broken.
    // 0 good, 1 magic, 2 version, 3 zero type, 4 CRC, 5 sequence jump, 6 zero sequence,
    // 7 header only (nothing after the header is sent).
    task automatic add_record(logic [63:0] seq, logic [15:0] typ, logic [31:0] len,
                              int corrupt);
        logic [7:0]   hdr[20];
        logic [31:0]  c;
        logic [7:0]   b;
        logic [159:0] hv;
        c = '1;
        hv = {32'h41434A52, 16'd1, typ, seq, len};
        if (corrupt == 1) hv[159 - $urandom_range(0, 31)] ^= 1'b1;
        if (corrupt == 2) hv[127 - $urandom_range(0, 15)] ^= 1'b1;
        if (corrupt == 3) hv[111:96] = '0;
        if (corrupt == 5) hv[95:32] = seq + 64'd2;
        if (corrupt == 6) hv[95:32] = '0;
        for (int i = 0; i < 20; i++) begin
            hdr[i] = hv[159 - 8*i -: 8];
            c = crc32_step(c, hdr[i]);
            add_byte(hdr[i]);
        end
        if (corrupt == 7) return;
        for (int i = 0; i < int'(len); i++) begin
            b = 8'($urandom);
            c = crc32_step(c, b);
            add_byte(b);
        end
        c = ~c;
        if (corrupt == 4) c[$urandom_range(0, 31)] ^= 1'b1;
        for (int i = 3; i >= 0; i--) add_byte(c[8*i +: 8]);
    endtask

    // Ends the stream either on its last byte or with a bare end marker.
    task automatic end_stream();
        if (pending_bytes.size() > 0 && !pending_bytes[$].end_of_stream
                && $urandom_range(0, 1)) begin
            pending_bytes[$].end_of_stream = 1'b1;
        end else begin
            add_bare_end();
        end
    endtask

    // Random stream: mostly well-formed records, some broken or cut off.
    task automatic add_random_stream(logic [63:0] first_seq, logic [31:0] max_len);
        int n_rec, corrupt, cut;
        logic [63:0] seq;
        logic [31:0] len;
        n_rec = $urandom_range(1, 2);
        seq = first_seq;
        for (int r = 0; r < n_rec; r++) begin
            len = $urandom_range(0, 100) < 80 ? 32'($urandom_range(0, 6))
                                              : 32'($urandom_range(0, 24));
            if (len > max_len) len = max_len;
            corrupt = $urandom_range(0, 99) < 80 ? 0 : $urandom_range(1, 6);
            add_record(seq, 16'($urandom_range(1, 65535)), len, corrupt);
            seq++;
        end
        cut = $urandom_range(0, 9);
        if (cut == 0) begin
            // Truncated tail: drop a few trailing bytes of the last record.
            for (int i = $urandom_range(1, 6); i > 0 && pending_bytes.size() > 0; i--)
                void'(pending_bytes.pop_back());
        end else if (cut == 1) begin
            // Noise bytes after the last record.
            for (int i = $urandom_range(1, 8); i > 0; i--) add_byte(8'($urandom));
        end
        end_stream();
    endtask

    task automatic cfg_write(logic idx, logic [63:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == jrsc_pkg::REG_MAX_PAYLOAD)
            lim_payload = (val[31:0] == 0) ? 32'd1 : val[31:0];
        else skip_seq = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain_and_settle();
        wait (pending_bytes.size() == 0 && !push);
        wait (owed_results.size() == 0);
        repeat (10) @(posedge i_clk);
    endtask

    // Accept tracking sampled at the rising edge.
    bit accepted_last = 1'b0;

    // Driver: presents queued items at the falling edge with random gaps.
    int send_gap = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!push || accepted_last) begin
                if (send_gap > 0 || sender_hold || pending_bytes.size() == 0) begin
                    if (send_gap > 0) send_gap <= send_gap - 1;
                    push <= 1'b0;
                end else begin
                    {i_data_byte, i_byte_present, i_end_of_stream} <= pending_bytes.pop_front();
                    push <= 1'b1;
                    send_gap <= ($urandom_range(0, 99) < 50) ? 0
                              : ($urandom_range(0, 99) < 90 ? $urandom_range(1, 3)
                                                            : $urandom_range(8, 30));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        accepted_last <= i_rst_n && push && !full;
        if (i_rst_n && push && !full) predict_stream_item({i_data_byte, i_byte_present,
                                                           i_end_of_stream});
    end

    // Receiver: pop with random stalls, plus one long forced hold-off.
    int pop_gap = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n || receiver_hold) begin
            pop <= 1'b0;
        end else if (pop_gap > 0) begin
            pop_gap <= pop_gap - 1;
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
            pop_gap <= ($urandom_range(0, 99) < 50) ? 0
                     : ($urandom_range(0, 99) < 90 ? $urandom_range(1, 3)
                                                   : $urandom_range(8, 30));
        end
    end

    // Monitor: compares each popped result with the oldest prediction.
    always @(posedge i_clk) begin
        jrsc_pkg::t_result want;
        if (i_rst_n && pop && !empty) begin
            if (owed_results.size() == 0) begin
                $error("result with no prediction waiting: kind %0d", o_kind);
                mismatch_count++;
            end else begin
                want = owed_results.pop_front();
                if (o_kind != want.kind) begin
                    $error("kind: expected %0d, actual %0d", want.kind, o_kind);
                    mismatch_count++;
                end
                if (o_record_sequence != want.record_sequence) begin
                    $error("record_sequence: expected %0h, actual %0h",
                           want.record_sequence, o_record_sequence);
                    mismatch_count++;
                end
                if (o_record_type != want.record_type) begin
                    $error("record_type: expected %0h, actual %0h",
                           want.record_type, o_record_type);
                    mismatch_count++;
                end
                if (o_payload_length != want.payload_length) begin
                    $error("payload_length: expected %0d, actual %0d",
                           want.payload_length, o_payload_length);
                    mismatch_count++;
                end
                if (o_byte_position != want.byte_position) begin
                    $error("byte_position: expected %0d, actual %0d",
                           want.byte_position, o_byte_position);
                    mismatch_count++;
                end
                if (o_applied_count != want.applied_count) begin
                    $error("applied_count: expected %0d, actual %0d",
                           want.applied_count, o_applied_count);
                    mismatch_count++;
                end
                if (o_ignored_count != want.ignored_count) begin
                    $error("ignored_count: expected %0d, actual %0d",
                           want.ignored_count, o_ignored_count);
                    mismatch_count++;
                end
                if (o_last_of_run != want.last_of_run) begin
                    $error("last_of_run: expected %0d, actual %0d",
                           want.last_of_run, o_last_of_run);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: cycles in which neither side moved an item.
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || !i_rst_n) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        logic [63:0] seq;
        lim_payload = 32'd65536;
        skip_seq = '0;
        restart_stream();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: empty stream, good records, each header fault, CRC cases.
        add_bare_end();
        add_record(64'd1, 16'hFFFF, 32'd0, 0);
        add_record(64'd2, 16'h0001, 32'd3, 0);
        end_stream();
        add_record(64'd1, 16'h0007, 32'd2, 1); add_bare_end();
        add_record(64'd1, 16'h0007, 32'd2, 2); add_bare_end();
        add_record(64'd1, 16'h0007, 32'd2, 3); add_byte(8'hFF, 1'b1);
        add_record(64'd1, 16'h0007, 32'd2, 6); add_bare_end();
        add_record(64'd5, 16'h0007, 32'd1, 0);
        add_record(64'd5, 16'h0007, 32'd1, 5); add_bare_end();
        // Declared length above the default limit; the header alone is enough.
        add_record(64'd1, 16'h0007, 32'd70000, 7); add_bare_end();
        // Bad CRC at the very end of the stream is a truncated tail.
        add_record(64'd3, 16'h0002, 32'd1, 4);
        pending_bytes[$].end_of_stream = 1'b1;
        add_record(64'd3, 16'h0002, 32'd1, 4); add_bare_end();
        // Bad CRC followed by another byte is a checksum error.
        add_record(64'd3, 16'h0002, 32'd1, 4); add_byte(8'h00); add_byte(8'h55);
        add_bare_end();
        // Header cut off partway.
        add_byte(8'h41); add_byte(8'h43, 1'b1);
        // Sequence at the top of its range.
        add_record(64'hFFFF_FFFF_FFFF_FFFF, 16'h8000, 32'd0, 0); add_bare_end();
        drain_and_settle();

        // Small payload limit and skip threshold, then the extremes.
        cfg_write(jrsc_pkg::REG_MAX_PAYLOAD, 64'd4);
        cfg_write(jrsc_pkg::REG_SKIP_SEQ, 64'd2);
        add_record(64'd1, 16'h0003, 32'd4, 0);
        add_record(64'd2, 16'h0003, 32'd4, 0);
        add_record(64'd3, 16'h0003, 32'd4, 0);
        add_record(64'd4, 16'h0003, 32'd5, 0);
        add_bare_end();
        drain_and_settle();
        cfg_write(jrsc_pkg::REG_MAX_PAYLOAD, 64'd0);
        cfg_write(jrsc_pkg::REG_SKIP_SEQ, 64'hFFFF_FFFF_FFFF_FFFF);
        add_record(64'd9, 16'h0003, 32'd1, 0);
        add_record(64'd10, 16'h0003, 32'd2, 0);
        end_stream();
        drain_and_settle();
        cfg_write(jrsc_pkg::REG_MAX_PAYLOAD, 64'hFFFF_FFFF);

        // Random phases under several settings.
        for (int phase_n = 0; phase_n < 4; phase_n++) begin
            cfg_write(jrsc_pkg::REG_SKIP_SEQ, 64'($urandom_range(0, 8)));
            cfg_write(jrsc_pkg::REG_MAX_PAYLOAD,
                      phase_n == 1 ? 64'd3 : 64'($urandom_range(6, 40)));
            if (phase_n == 2) begin
                // The receiver holds off while the sender keeps offering items. Three
                // empty streams up front leave three results waiting, so the block
                // fills up and stalls its input.
                receiver_hold = 1'b1;
                repeat (3) add_bare_end();
            end
            for (int s = 0; s < 2; s++) begin
                seq = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                                  : 64'($urandom_range(1, 6));
                if (seq == 0) seq = 1;
                add_random_stream(seq, lim_payload);
            end
            if (phase_n == 2) begin
                repeat (300) @(posedge i_clk);
                receiver_hold = 1'b0;
            end
            if (phase_n == 1) begin
                // The sender pauses until every owed result has arrived.
                wait (pending_bytes.size() == 0 && !push);
                sender_hold = 1'b1;
                wait (owed_results.size() == 0);
                sender_hold = 1'b0;
            end
            drain_and_settle();
        end

        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && owed_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            if (owed_results.size() != 0)
                $error("%0d predicted results never arrived", owed_results.size());
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
